### rtl/i2p_pkg.sv
// ----------------------------------------------------------------------------
// i2p_pkg
// Shared types and codes for the infix to postfix converter.
// ----------------------------------------------------------------------------
package i2p_pkg;

    // Input token kinds
    localparam logic [3:0] KIND_NUMBER    = 4'd0;
    localparam logic [3:0] KIND_VARIABLE  = 4'd1;
    localparam logic [3:0] KIND_OPERATOR  = 4'd2;
    localparam logic [3:0] KIND_FUNCTION  = 4'd3;
    localparam logic [3:0] KIND_SPECIAL   = 4'd4;
    localparam logic [3:0] KIND_LPAREN    = 4'd5;
    localparam logic [3:0] KIND_RPAREN    = 4'd6;
    localparam logic [3:0] KIND_SEPARATOR = 4'd7;
    localparam logic [3:0] KIND_ERROR     = 4'd8;
    localparam logic [3:0] KIND_END       = 4'd9;

    // Output token kinds
    localparam logic [1:0] OKIND_OPERAND  = 2'd0;
    localparam logic [1:0] OKIND_OPERATOR = 2'd1;
    localparam logic [1:0] OKIND_FUNCTION = 2'd2;
    localparam logic [1:0] OKIND_SPECIAL  = 2'd3;

    // Result status codes
    localparam logic [2:0] ST_TOKEN         = 3'd0;
    localparam logic [2:0] ST_DONE          = 3'd1;
    localparam logic [2:0] ST_ERROR_TOKEN   = 3'd2;
    localparam logic [2:0] ST_UNMATCHED_RP  = 3'd3;
    localparam logic [2:0] ST_BAD_SEPARATOR = 3'd4;
    localparam logic [2:0] ST_UNMATCHED_LP  = 3'd5;
    localparam logic [2:0] ST_OVERFLOW      = 3'd6;
    localparam logic [2:0] ST_UNKNOWN_KIND  = 3'd7;

    // What an operator stack entry holds
    typedef enum logic [1:0] {
        SC_OPER = 2'd0,
        SC_FUNC = 2'd1,
        SC_SPEC = 2'd2,
        SC_LPAR = 2'd3
    } stack_code_t;

    typedef struct packed {
        stack_code_t code;
        logic        unary;
        logic [3:0]  prec;
        logic [15:0] id;
    } stack_entry_t;

    typedef struct packed {
        logic [3:0]  token_kind;
        logic [15:0] token_id;
        logic [3:0]  precedence;
    } token_beat_t;

    typedef struct packed {
        logic [15:0] out_token_id;
        logic [1:0]  out_kind;
        logic [3:0]  out_precedence;
        logic        out_unary;
        logic [2:0]  out_status;
        logic        out_last;
    } result_beat_t;

    // Controller to datapath
    typedef struct packed {
        logic       load;
        logic       pop;
        logic       pop_emit;
        logic       push;
        logic       emit_status;
        logic       emit_operand;
        logic [2:0] status;
        logic       finish;
        logic       end_clear;
        logic       fail;
        logic       exp_set;
        logic       exp_clr;
    } i2p_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic [3:0]  kind;
        logic [3:0]  prec;
        logic        count_zero;
        logic        count_full;
        stack_code_t top_code;
        logic [3:0]  top_prec;
        logic        lparen_any;
        logic        err;
        logic [2:0]  err_code;
        logic        can_emit;
    } i2p_sts_t;

endpackage

### rtl/i2p_ram.sv
// ----------------------------------------------------------------------------
// i2p_ram
// Generic single write port RAM with one registered read port.
// ----------------------------------------------------------------------------
module i2p_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                              clk,
    input  logic                              we,
    input  logic [$clog2(DEPTH)-1:0]          waddr,
    input  logic [WIDTH-1:0]                  wdata,
    input  logic                              re,
    input  logic [$clog2(DEPTH)-1:0]          raddr,
    output logic [WIDTH-1:0]                  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### rtl/i2p_dpath.sv
// ----------------------------------------------------------------------------
// i2p_dpath
// Token register, operator stack, flags and result hold/output registers.
// ----------------------------------------------------------------------------
module i2p_dpath
    import i2p_pkg::*;
#(
    parameter int STACK_DEPTH = 32
) (
    input  logic         clk,
    input  logic         rst_n,
    input  token_beat_t  token,
    input  i2p_cmd_t     cmd,
    output i2p_sts_t     sts,
    output logic         result_valid,
    input  logic         result_ready,
    output result_beat_t result
);

    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int AW = $clog2(STACK_DEPTH);
    localparam int EW = $bits(stack_entry_t);

    token_beat_t  tok_reg;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] lpar_reg, lpar_next;
    logic [CW-1:0] count_m2;
    stack_entry_t top_reg;
    logic         top_ram_reg;
    stack_entry_t top;
    stack_entry_t push_entry;
    logic [EW-1:0] ram_rdata;
    logic         ram_re;
    logic         exp_reg;
    logic         err_reg;
    logic [2:0]   code_reg;

    result_beat_t hold_reg, out_reg, out_next, res_new;
    logic         hold_valid_reg, hold_final_reg, out_valid_reg;
    logic         out_free, emit, move;

    // Stack storage
    assign count_m2 = count_reg - CW'(2);
    assign ram_re   = cmd.pop && (count_reg > CW'(1));

    i2p_ram #(
        .WIDTH (EW),
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .clk   (clk),
        .we    (cmd.push),
        .waddr (count_reg[AW-1:0]),
        .wdata (push_entry),
        .re    (ram_re),
        .raddr (count_m2[AW-1:0]),
        .rdata (ram_rdata)
    );

    assign top = top_ram_reg ? stack_entry_t'(ram_rdata) : top_reg;

    always_comb
    begin
        push_entry.id    = tok_reg.token_id;
        push_entry.prec  = tok_reg.precedence;
        push_entry.unary = exp_reg && (tok_reg.token_kind == KIND_OPERATOR);
        case (tok_reg.token_kind)
            KIND_OPERATOR: push_entry.code = SC_OPER;
            KIND_FUNCTION: push_entry.code = SC_FUNC;
            KIND_SPECIAL:  push_entry.code = SC_SPEC;
            default:       push_entry.code = SC_LPAR;
        endcase
    end

    always_comb
    begin
        count_next = count_reg;
        lpar_next  = lpar_reg;
        if (cmd.fail || cmd.end_clear)
        begin
            count_next = '0;
            lpar_next  = '0;
        end
        else if (cmd.push)
        begin
            count_next = count_reg + CW'(1);
            if (tok_reg.token_kind == KIND_LPAREN)
            begin
                lpar_next = lpar_reg + CW'(1);
            end
        end
        else if (cmd.pop)
        begin
            count_next = count_reg - CW'(1);
            if (!cmd.pop_emit)
            begin
                lpar_next = lpar_reg - CW'(1);
            end
        end
    end

    // Result selection
    always_comb
    begin
        res_new                = '0;
        res_new.out_token_id   = tok_reg.token_id;
        if (cmd.pop_emit)
        begin
            res_new.out_token_id = top.id;
            case (top.code)
                SC_OPER:
                begin
                    res_new.out_kind       = OKIND_OPERATOR;
                    res_new.out_precedence = top.prec;
                    res_new.out_unary      = top.unary;
                end
                SC_FUNC: res_new.out_kind = OKIND_FUNCTION;
                default: res_new.out_kind = OKIND_SPECIAL;
            endcase
        end
        else if (cmd.emit_status)
        begin
            res_new.out_status = cmd.status;
        end
    end

    assign emit     = cmd.pop_emit || cmd.emit_status || cmd.emit_operand;
    assign out_free = !out_valid_reg || result_ready;
    assign move     = hold_valid_reg && (emit || hold_final_reg) && out_free;

    always_comb
    begin
        out_next          = hold_reg;
        out_next.out_last = hold_final_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg      <= '0;
            lpar_reg       <= '0;
            top_ram_reg    <= 1'b0;
            exp_reg        <= 1'b1;
            err_reg        <= 1'b0;
            code_reg       <= ST_TOKEN;
            hold_valid_reg <= 1'b0;
            hold_final_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            lpar_reg  <= lpar_next;
            if (cmd.push)
            begin
                top_ram_reg <= 1'b0;
            end
            else if (cmd.pop)
            begin
                top_ram_reg <= 1'b1;
            end

            if (cmd.end_clear || cmd.exp_set)
            begin
                exp_reg <= 1'b1;
            end
            else if (cmd.exp_clr)
            begin
                exp_reg <= 1'b0;
            end

            if (cmd.fail)
            begin
                err_reg  <= 1'b1;
                code_reg <= cmd.status;
            end
            else if (cmd.end_clear)
            begin
                err_reg  <= 1'b0;
                code_reg <= ST_TOKEN;
            end

            // Hold one result back until it is known whether it ends the item
            if (emit)
            begin
                hold_valid_reg <= 1'b1;
                hold_final_reg <= cmd.finish;
            end
            else
            begin
                if (move)
                begin
                    hold_valid_reg <= 1'b0;
                end
                if (cmd.finish)
                begin
                    hold_final_reg <= 1'b1;
                end
            end

            if (move)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            tok_reg <= token;
        end
        if (cmd.push)
        begin
            top_reg <= push_entry;
        end
        if (emit)
        begin
            hold_reg <= res_new;
        end
        if (move)
        begin
            out_reg <= out_next;
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    always_comb
    begin
        sts.kind       = tok_reg.token_kind;
        sts.prec       = tok_reg.precedence;
        sts.count_zero = (count_reg == '0);
        sts.count_full = (count_reg == CW'(STACK_DEPTH));
        sts.top_code   = top.code;
        sts.top_prec   = top.prec;
        sts.lparen_any = (lpar_reg != '0);
        sts.err        = err_reg;
        sts.err_code   = code_reg;
        sts.can_emit   = !hold_valid_reg || out_free;
    end

endmodule

### rtl/i2p_ctrl.sv
// ----------------------------------------------------------------------------
// i2p_ctrl
// Sequencer: decides per cycle whether to pop, push, emit or finish a token.
// ----------------------------------------------------------------------------
module i2p_ctrl
    import i2p_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     token_valid,
    output logic     token_ready,
    input  i2p_sts_t sts,
    output i2p_cmd_t cmd
);

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_EXEC  = 3'b010,
        S_RFUNC = 3'b100
    } state_t;

    state_t     state_reg, state_next;
    logic       do_fail;
    logic       do_end;
    logic [2:0] st_code;
    logic       top_poppable;
    logic       top_is_func;

    assign top_poppable = !sts.count_zero && (sts.top_code == SC_OPER) &&
                          (sts.top_prec >= sts.prec);
    assign top_is_func  = !sts.count_zero &&
                          ((sts.top_code == SC_FUNC) || (sts.top_code == SC_SPEC));
    assign token_ready  = (state_reg == S_IDLE);

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        do_fail    = 1'b0;
        do_end     = 1'b0;
        st_code    = ST_TOKEN;
        case (state_reg)
            S_IDLE:
            begin
                if (token_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (sts.kind == KIND_END)
                begin
                    if (sts.err)
                    begin
                        do_end  = 1'b1;
                        st_code = sts.err_code;
                    end
                    else if (sts.lparen_any)
                    begin
                        do_end  = 1'b1;
                        st_code = ST_UNMATCHED_LP;
                    end
                    else if (!sts.count_zero)
                    begin
                        if (sts.can_emit)
                        begin
                            cmd.pop      = 1'b1;
                            cmd.pop_emit = 1'b1;
                        end
                    end
                    else
                    begin
                        do_end  = 1'b1;
                        st_code = ST_DONE;
                    end
                end
                else if (sts.err)
                begin
                    // drop everything until the end token
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    case (sts.kind)
                        KIND_NUMBER, KIND_VARIABLE:
                        begin
                            if (sts.can_emit)
                            begin
                                cmd.emit_operand = 1'b1;
                                cmd.exp_clr      = 1'b1;
                                cmd.finish       = 1'b1;
                                state_next       = S_IDLE;
                            end
                        end
                        KIND_OPERATOR:
                        begin
                            if (top_poppable)
                            begin
                                if (sts.can_emit)
                                begin
                                    cmd.pop      = 1'b1;
                                    cmd.pop_emit = 1'b1;
                                end
                            end
                            else if (sts.count_full)
                            begin
                                do_fail = 1'b1;
                                st_code = ST_OVERFLOW;
                            end
                            else
                            begin
                                cmd.push    = 1'b1;
                                cmd.exp_set = 1'b1;
                                cmd.finish  = 1'b1;
                                state_next  = S_IDLE;
                            end
                        end
                        KIND_FUNCTION, KIND_SPECIAL, KIND_LPAREN:
                        begin
                            if (sts.count_full)
                            begin
                                do_fail = 1'b1;
                                st_code = ST_OVERFLOW;
                            end
                            else
                            begin
                                cmd.push    = 1'b1;
                                cmd.exp_set = 1'b1;
                                cmd.finish  = 1'b1;
                                state_next  = S_IDLE;
                            end
                        end
                        KIND_RPAREN:
                        begin
                            if (!sts.lparen_any)
                            begin
                                do_fail = 1'b1;
                                st_code = ST_UNMATCHED_RP;
                            end
                            else if (sts.top_code == SC_LPAR)
                            begin
                                // discard the matching paren, then check for a function
                                cmd.pop    = 1'b1;
                                state_next = S_RFUNC;
                            end
                            else if (sts.can_emit)
                            begin
                                cmd.pop      = 1'b1;
                                cmd.pop_emit = 1'b1;
                            end
                        end
                        KIND_SEPARATOR:
                        begin
                            if (!sts.lparen_any)
                            begin
                                do_fail = 1'b1;
                                st_code = ST_BAD_SEPARATOR;
                            end
                            else if (sts.top_code == SC_LPAR)
                            begin
                                cmd.exp_set = 1'b1;
                                cmd.finish  = 1'b1;
                                state_next  = S_IDLE;
                            end
                            else if (sts.can_emit)
                            begin
                                cmd.pop      = 1'b1;
                                cmd.pop_emit = 1'b1;
                            end
                        end
                        KIND_ERROR:
                        begin
                            do_fail = 1'b1;
                            st_code = ST_ERROR_TOKEN;
                        end
                        default:
                        begin
                            do_fail = 1'b1;
                            st_code = ST_UNKNOWN_KIND;
                        end
                    endcase
                end

                if ((do_fail || do_end) && sts.can_emit)
                begin
                    cmd.emit_status = 1'b1;
                    cmd.status      = st_code;
                    cmd.fail        = do_fail;
                    cmd.end_clear   = do_end;
                    cmd.finish      = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            S_RFUNC:
            begin
                if (top_is_func)
                begin
                    if (sts.can_emit)
                    begin
                        cmd.pop      = 1'b1;
                        cmd.pop_emit = 1'b1;
                        cmd.exp_clr  = 1'b1;
                        cmd.finish   = 1'b1;
                        state_next   = S_IDLE;
                    end
                end
                else
                begin
                    cmd.exp_clr = 1'b1;
                    cmd.finish  = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

### rtl/infix_to_postfix_converter_unit.sv
// ----------------------------------------------------------------------------
// infix_to_postfix_converter_unit
// Shunting-yard converter: one infix token in, zero or more postfix beats out.
// Each token beat is taken in while the sequencer is idle; the sequencer then
// works through the stack pops and emitted results of that token in turn and
// then pushes it or finishes, and no new token is taken until it has finished.
// A right parenthesis pops the entries above its left parenthesis, then drops
// the left parenthesis, then emits the function under it or finishes. Pops
// run one per cycle while the output has room, paced by the registered read
// of the stack RAM. The last result of a token carries out_last; tokens that
// cause no result (pushes, drops after an error) give no beat. The stack RAM
// needs no clearing after reset.
// ----------------------------------------------------------------------------
module infix_to_postfix_converter_unit
    import i2p_pkg::*;
#(
    parameter int STACK_DEPTH = 32
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         token_valid,
    output logic         token_ready,
    input  token_beat_t  token,
    output logic         result_valid,
    input  logic         result_ready,
    output result_beat_t result
);

    i2p_cmd_t cmd;
    i2p_sts_t sts;

    i2p_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .token_valid (token_valid),
        .token_ready (token_ready),
        .sts         (sts),
        .cmd         (cmd)
    );

    i2p_dpath #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_dpath (
        .clk          (clk),
        .rst_n        (rst_n),
        .token        (token),
        .cmd          (cmd),
        .sts          (sts),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

`ifndef SYNTH
    // A token beat is taken only when the sequencer is free
    a_one_token: assert property (@(posedge clk) disable iff (!rst_n)
        (token_valid && token_ready) |=> !token_ready)
        else $error("token taken while busy");

    a_lparen_in_stack: assert property (@(posedge clk) disable iff (!rst_n)
        sts.lparen_any |-> !sts.count_zero)
        else $error("left paren count exceeds stack");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.pop |-> !sts.count_zero)
        else $error("pop from empty stack");

    a_emit_room: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.pop_emit || cmd.emit_status || cmd.emit_operand) |-> sts.can_emit)
        else $error("result emitted with no room");
`endif

endmodule
